// ===== sv/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and the reciprocal table for the 3x3 box blur.
// No dependencies.
package bb3_pkg;

    // configuration register indexes
    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam int CFG_DATA_W = 13;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

    // input word kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // mean = (2*sum + n) * ceil(2^RECIP_SHIFT / (2n)) >> RECIP_SHIFT, exact for sum <= 9*255
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam int NUM_W       = 13;
    localparam int PROD_W      = RECIP_SHIFT + 8;
    localparam int SUM_W       = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       run_last;
        logic       frame_last;
    } t_pix_out;

    // window plus which rows and columns lie inside the frame; index [row][col]
    typedef struct packed {
        t_rgb [2:0][2:0] win;
        logic [2:0]      row_en;
        logic [2:0]      col_en;
    } t_mean_req;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/box_blur_3x3.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 box blur: sequencer, two line stores, window.
// Depends on bb3_pkg, bb3_ram, bb3_mean.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_stall | t_pix_in: mode + RGB
//  out     | out       | o_out_valid / i_out_stall | t_pix_out: RGB + flags
//  cfg     | in        | i_cfg_we                | index + 13-bit data
//
// One word is worked on at a time. A pixel word gives no result, one, or two at
// the end of a row; a drain word gives one, or none when no final-row pixel is
// pending. The pace is set by the single read port of the line stores, the
// two-stage mean unit and any stall of the output.
// Reset is synchronous, active low, and needs no clearing pass of the stores.
// The output register holds a word under stall while the next input is taken.
module box_blur_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bb3_pkg::t_pix_in                    i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bb3_pkg::t_pix_out                   o_out_word,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bb3_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WVW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HVW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PIX, S_DRAIN0, S_DRAIN1, S_DRAIN2, S_WAIT1, S_WAIT2, S_EMIT
    } t_state;

    t_state          r_state;
    logic [10:0]     r_image_width;
    logic [12:0]     r_image_height;
    logic [RW-1:0]   r_in_row;
    logic [CW-1:0]   r_in_col;
    logic [CW-1:0]   r_drain_col;
    logic            r_draining;
    logic [RW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    t_rgb            r_pix;
    t_rgb [2:0][2:0] r_win;
    logic [2:0]      r_row_en;
    logic [2:0]      r_col_en;
    logic            r_extra_pend;
    logic            r_run_last;
    logic            r_frame_last;
    logic            r_out_valid;
    t_pix_out        r_out_word;

    logic [WVW-1:0]  w_eff;
    logic [HVW-1:0]  h_eff;
    logic            accept;
    logic            ram_re;
    logic [CW-1:0]   n_raddr;
    t_rgb            older_q;
    t_rgb            newer_q;
    logic            out_free;
    logic            j_last, i_last, d_last;
    logic            main_out, extra_out;
    logic [2:0]      extra_mask;
    t_mean_req       mean_req;
    t_rgb            mean_rgb;

    // registers in use are clamped into range
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WVW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = WVW'(MAX_WIDTH);
        end else begin
            w_eff = WVW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = HVW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_eff = HVW'(MAX_HEIGHT);
        end else begin
            h_eff = HVW'(r_image_height);
        end
    end

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign j_last    = ((WVW'(r_j) + WVW'(1)) == w_eff);
    assign i_last    = ((HVW'(r_i) + HVW'(1)) == h_eff);
    assign d_last    = ((WVW'(r_drain_col) + WVW'(1)) == w_eff);
    assign main_out  = (r_i != '0) && (r_j != '0);
    assign extra_out = (r_i != '0) && j_last;
    // last column of a row: centered on the newest column
    assign extra_mask = {1'b1, (32'(w_eff) >= 32'd2), 1'b0};

    // line store reads
    always_comb begin
        ram_re  = 1'b0;
        n_raddr = r_in_col;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ram_re = 1'b1;
                    if (i_in_word.mode == MODE_DRAIN) begin
                        n_raddr = r_drain_col - CW'(1);
                    end else begin
                        n_raddr = r_draining ? '0 : r_in_col;
                    end
                end
            end
            S_DRAIN0: begin
                ram_re  = 1'b1;
                n_raddr = r_drain_col;
            end
            S_DRAIN1: begin
                ram_re  = 1'b1;
                n_raddr = r_drain_col + CW'(1);
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PIX),
        .i_waddr (r_j),
        .i_wdata (newer_q),
        .i_re    (ram_re),
        .i_raddr (n_raddr),
        .o_rdata (older_q)
    );

    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PIX),
        .i_waddr (r_j),
        .i_wdata (r_pix),
        .i_re    (ram_re),
        .i_raddr (n_raddr),
        .o_rdata (newer_q)
    );

    assign mean_req.win    = r_win;
    assign mean_req.row_en = r_row_en;
    assign mean_req.col_en = r_col_en;

    bb3_mean u_mean (
        .i_clk (i_clk),
        .i_req (mean_req),
        .o_rgb (mean_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_drain_col    <= '0;
            r_draining     <= 1'b0;
            r_extra_pend   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_word.mode == MODE_DRAIN) begin
                            if (r_draining) begin
                                r_state <= S_DRAIN0;
                            end
                        end else begin
                            r_i           <= r_draining ? '0 : r_in_row;
                            r_j           <= r_draining ? '0 : r_in_col;
                            r_pix.red     <= i_in_word.pixel_red;
                            r_pix.green   <= i_in_word.pixel_green;
                            r_pix.blue    <= i_in_word.pixel_blue;
                            r_draining    <= 1'b0;
                            r_drain_col   <= '0;
                            r_state       <= S_PIX;
                        end
                    end
                end
                S_PIX: begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r][0] <= r_win[r][1];
                        r_win[r][1] <= r_win[r][2];
                    end
                    r_win[0][2]  <= older_q;
                    r_win[1][2]  <= newer_q;
                    r_win[2][2]  <= r_pix;
                    r_row_en     <= {1'b1, 1'b1, (32'(r_i) >= 32'd2)};
                    r_frame_last <= 1'b0;
                    if (main_out) begin
                        r_col_en     <= {1'b1, 1'b1, (32'(r_j) >= 32'd2)};
                        r_extra_pend <= extra_out;
                        r_run_last   <= !extra_out;
                        r_state      <= S_WAIT1;
                    end else if (extra_out) begin
                        r_col_en     <= extra_mask;
                        r_extra_pend <= 1'b0;
                        r_run_last   <= 1'b1;
                        r_state      <= S_WAIT1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    if (j_last) begin
                        r_in_col <= '0;
                        if (i_last) begin
                            r_in_row    <= '0;
                            r_draining  <= 1'b1;
                            r_drain_col <= '0;
                        end else begin
                            r_in_row <= r_i + RW'(1);
                        end
                    end else begin
                        r_in_col <= r_j + CW'(1);
                    end
                end
                S_DRAIN0: begin
                    r_win[0][0] <= older_q;
                    r_win[1][0] <= newer_q;
                    r_state     <= S_DRAIN1;
                end
                S_DRAIN1: begin
                    r_win[0][1] <= older_q;
                    r_win[1][1] <= newer_q;
                    r_state     <= S_DRAIN2;
                end
                S_DRAIN2: begin
                    // final row: older store is the row above, newer store the row itself
                    r_win[0][2]  <= older_q;
                    r_win[1][2]  <= newer_q;
                    r_row_en     <= {1'b0, 1'b1, (32'(h_eff) >= 32'd2)};
                    r_col_en     <= {!d_last, 1'b1, (r_drain_col != '0)};
                    r_frame_last <= d_last;
                    r_run_last   <= 1'b1;
                    r_extra_pend <= 1'b0;
                    r_drain_col  <= d_last ? '0 : r_drain_col + CW'(1);
                    r_draining   <= !d_last;
                    r_state      <= S_WAIT1;
                end
                S_WAIT1: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_word.out_red    <= mean_rgb.red;
                        r_out_word.out_green  <= mean_rgb.green;
                        r_out_word.out_blue   <= mean_rgb.blue;
                        r_out_word.run_last   <= r_run_last;
                        r_out_word.frame_last <= r_frame_last;
                        if (r_extra_pend) begin
                            r_col_en     <= extra_mask;
                            r_extra_pend <= 1'b0;
                            r_run_last   <= 1'b1;
                            r_state      <= S_WAIT1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // any register write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[10:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[12:0];
                    default:          r_image_width  <= r_image_width;
                endcase
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_drain_col <= '0;
                r_draining  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/bb3_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bb3_mean.sv =====
`timescale 1ns / 1ps
// Two-stage rounded mean of the in-frame part of a 3x3 window, per channel.
// Depends on bb3_pkg.
module bb3_mean (
    input  logic              i_clk,
    input  bb3_pkg::t_mean_req i_req,
    output bb3_pkg::t_rgb     o_rgb
);
    import bb3_pkg::*;

    logic [SUM_W-1:0]  n_sum_r, n_sum_g, n_sum_b;
    logic [3:0]        n_count;
    logic [SUM_W-1:0]  r_sum_r, r_sum_g, r_sum_b;
    logic [3:0]        r_count;
    logic [NUM_W-1:0]  num_r, num_g, num_b;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;

    // stage 1: masked sums and neighbor count
    always_comb begin
        n_sum_r = '0;
        n_sum_g = '0;
        n_sum_b = '0;
        n_count = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (i_req.row_en[r] && i_req.col_en[c]) begin
                    n_sum_r = n_sum_r + SUM_W'(i_req.win[r][c].red);
                    n_sum_g = n_sum_g + SUM_W'(i_req.win[r][c].green);
                    n_sum_b = n_sum_b + SUM_W'(i_req.win[r][c].blue);
                    n_count = n_count + 4'd1;
                end
            end
        end
    end

    // stage 2: (2s + n) times reciprocal of 2n
    assign num_r = NUM_W'({r_sum_r, 1'b0}) + NUM_W'(r_count);
    assign num_g = NUM_W'({r_sum_g, 1'b0}) + NUM_W'(r_count);
    assign num_b = NUM_W'({r_sum_b, 1'b0}) + NUM_W'(r_count);
    assign recip = recip_of(r_count);

    always_ff @(posedge i_clk) begin
        r_sum_r  <= n_sum_r;
        r_sum_g  <= n_sum_g;
        r_sum_b  <= n_sum_b;
        r_count  <= n_count;
        r_prod_r <= PROD_W'(33'(num_r) * 33'(recip));
        r_prod_g <= PROD_W'(33'(num_g) * 33'(recip));
        r_prod_b <= PROD_W'(33'(num_b) * 33'(recip));
    end

    assign o_rgb.red   = r_prod_r[RECIP_SHIFT +: 8];
    assign o_rgb.green = r_prod_g[RECIP_SHIFT +: 8];
    assign o_rgb.blue  = r_prod_b[RECIP_SHIFT +: 8];

endmodule
